>>> sv/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared sizes, types and helper functions of the FIFO page replacement core.
// ----------------------------------------------------------------------------
package fpr_pkg;

   localparam int MAX_FRAMES = 16;
   localparam int PAGE_W     = 16;
   localparam int CFG_W      = 5;
   localparam int TOTAL_W    = 32;
   localparam int FILLED_W   = 5;
   localparam int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
   localparam int SUM_W      = CNT_W + 1;
   localparam int LIM_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(4);
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef logic [PAGE_W-1:0] page_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [CNT_W-1:0]  count_type;

   typedef struct packed {
      logic                  fault;
      logic                  evicted_valid;
      page_type              evicted_page;
      logic [TOTAL_W-1:0]    fault_total;
      logic [FILLED_W-1:0]   frames_filled;
   } result_type;

   // zero frames acts as one, anything above the ring size as the ring size
   function automatic count_type frame_limit(logic [CFG_W-1:0] cfg);
      logic [LIM_W-1:0] wide;
      wide = LIM_W'(cfg);
      if (cfg == '0) begin
         return CNT_W'(1);
      end else if (wide > LIM_W'(MAX_FRAMES)) begin
         return CNT_W'(MAX_FRAMES);
      end else begin
         return CNT_W'(wide);
      end
   endfunction

   // ring index base + offs, offs never above the ring size
   function automatic slot_type slot_add(slot_type base, count_type offs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offs);
      if (sum >= SUM_W'(MAX_FRAMES)) begin
         sum = sum - SUM_W'(MAX_FRAMES);
      end
      return SLOT_W'(sum);
   endfunction

endpackage

>>> sv/fpr_frame_store.sv
// ----------------------------------------------------------------------------
// fpr_frame_store
// Ring of resident pages with parallel lookup, FIFO insert/evict and the
// saturating fault counter. Updates its state on each fire pulse.
// ----------------------------------------------------------------------------
module fpr_frame_store
   import fpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  page_type   page,
   input  logic       start,
   input  count_type  limit,
   output result_type result
);

   page_type           pages_ff [MAX_FRAMES];
   count_type          count_ff;
   count_type          count_in;
   slot_type           oldest_ff;
   slot_type           oldest_in;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;

   count_type          count_eff;
   slot_type           oldest_eff;
   logic [TOTAL_W-1:0] total_eff;
   logic [MAX_FRAMES-1:0] hit_vec;
   logic               miss;
   logic               evict;
   slot_type           wr_slot;

   // distance of ring slot idx from the oldest slot
   function automatic logic [SUM_W-1:0] ring_offset(int idx, slot_type base);
      logic [SUM_W-1:0] pos;
      pos = SUM_W'(idx);
      if (pos >= SUM_W'(base)) begin
         return pos - SUM_W'(base);
      end else begin
         return pos + SUM_W'(MAX_FRAMES) - SUM_W'(base);
      end
   endfunction

   always_comb begin
      count_eff  = start ? '0 : count_ff;
      oldest_eff = start ? '0 : oldest_ff;
      total_eff  = start ? '0 : total_ff;

      for (int i = 0; i < MAX_FRAMES; i++) begin
         hit_vec[i] = (ring_offset(i, oldest_eff) < SUM_W'(count_eff)) &&
                      (pages_ff[i] == page);
      end

      miss    = ~|hit_vec;
      evict   = miss && !(count_eff < limit);
      wr_slot = slot_add(oldest_eff, count_eff);

      count_in  = count_eff;
      oldest_in = oldest_eff;
      total_in  = total_eff;
      if (miss) begin
         if (total_eff != TOTAL_MAX) begin
            total_in = total_eff + TOTAL_W'(1);
         end
         if (evict) begin
            oldest_in = slot_add(oldest_eff, CNT_W'(1));
         end else begin
            count_in = count_eff + CNT_W'(1);
         end
      end

      result.fault         = miss;
      result.evicted_valid = evict;
      result.evicted_page  = evict ? pages_ff[oldest_eff] : '0;
      result.fault_total   = total_in;
      result.frames_filled = FILLED_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (fire && miss) begin
         pages_ff[wr_slot] <= page;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         oldest_ff <= '0;
         total_ff  <= '0;
      end else if (fire) begin
         count_ff  <= count_in;
         oldest_ff <= oldest_in;
         total_ff  <= total_in;
      end
   end

endmodule

>>> sv/fifo_page_replacement_core.sv
// ----------------------------------------------------------------------------
// fifo_page_replacement_core
// FIFO page replacement, small frame ring, one reference per cycle without stall.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one page reference per item (page number and a
//   start flag that empties the frames and clears the fault count first).
//   rsp_ channel returns one result item per reference, in order: fault,
//   eviction flag and page, running fault count and frames filled.
//   csr_ channel writes the frame limit (reset value 4); write it only while
//   no item is in flight. csr_ready is always high.
// Timing:
//   a reference is registered in the input stage on acceptance; its result is
//   registered in the result stage when the item advances. One item per cycle
//   is sustained while rsp_stall is low; the lookup compares the page against
//   every frame in parallel and the ring update happens in that same cycle.
// Reset:
//   synchronous; empties the frames, clears the fault count and both stages.
// Stall:
//   while rsp_stall holds a result, the input stage keeps one more item and
//   then raises req_stall; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module fifo_page_replacement_core
   import fpr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [PAGE_W-1:0]   req_page_number,
   input  logic                req_start_run,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_fault,
   output logic                rsp_evicted_valid,
   output logic [PAGE_W-1:0]   rsp_evicted_page,
   output logic [TOTAL_W-1:0]  rsp_fault_total,
   output logic [FILLED_W-1:0] rsp_frames_filled,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_W-1:0]    csr_frames_in_use
);

   logic [CFG_W-1:0] frames_cfg_ff;

   logic       in_valid_ff;
   logic       in_valid_in;
   page_type   in_page_ff;
   logic       in_start_ff;

   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_ff;
   result_type result;

   logic       accept;
   logic       advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_cfg_ff <= CFG_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            frames_cfg_ff <= csr_frames_in_use;
         end
      end
   end

   // the held item moves on whenever the result register is free or drains
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_page_ff  <= req_page_number;
         in_start_ff <= req_start_run;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   fpr_frame_store u_store (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .page   (in_page_ff),
      .start  (in_start_ff),
      .limit  (frame_limit(frames_cfg_ff)),
      .result (result)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_fault         = out_ff.fault;
   assign rsp_evicted_valid = out_ff.evicted_valid;
   assign rsp_evicted_page  = out_ff.evicted_page;
   assign rsp_fault_total   = out_ff.fault_total;
   assign rsp_frames_filled = out_ff.frames_filled;

`ifndef NO_ASSERTIONS
   a_evict_needs_fault : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted_valid |-> rsp_fault)
      else $error("eviction reported without a fault");

   a_no_evict_zero_page : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> rsp_evicted_page == '0)
      else $error("evicted page nonzero without eviction");

   a_filled_bounded : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frames_filled != '0) && (rsp_frames_filled <= MAX_FRAMES))
      else $error("frames filled out of range");

   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");
`endif

endmodule

>>> bench/fifo_page_replacement_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_page_replacement_core_test
// Self-checking bench for the FIFO page replacement core: a page ring model
// predicts fault, eviction, fault count and fill level for every reference,
// and each returned item is compared field by field, in order. Both channels
// idle at random, the frame limit is rewritten between runs of traffic, and
// the result side holds off long enough to back the input up.
// ----------------------------------------------------------------------------
import fpr_pkg::*;

class page_ring_scoreboard;
   page_type           ring [MAX_FRAMES];
   int unsigned        resident;
   int unsigned        oldest;
   logic [TOTAL_W-1:0] fault_count;
   logic [CFG_W-1:0]   frames_cfg;
   result_type         awaited_results [$];
   int                 mismatches;
   int                 results_seen;
   int                 faults_seen;
   int                 evictions_seen;
   int                 hits_seen;
   int                 restarts_seen;

   function new();
      frames_cfg     = CFG_RESET;
      resident       = 0;
      oldest         = 0;
      fault_count    = '0;
      mismatches     = 0;
      results_seen   = 0;
      faults_seen    = 0;
      evictions_seen = 0;
      hits_seen      = 0;
      restarts_seen  = 0;
   endfunction

   function int unsigned frame_budget();
      if (frames_cfg == '0) begin
         return 1;
      end
      if (frames_cfg > MAX_FRAMES) begin
         return MAX_FRAMES;
      end
      return frames_cfg;
   endfunction

   function int pending();
      return awaited_results.size();
   endfunction

   // work out what the core must return for an accepted reference
   function void note_reference(page_type page, logic start);
      result_type  r;
      bit          hit;
      int unsigned i;
      int unsigned slot;
      r = '0;
      if (start) begin
         resident    = 0;
         oldest      = 0;
         fault_count = '0;
         restarts_seen++;
      end
      hit = 1'b0;
      for (i = 0; i < resident; i++) begin
         if (ring[(oldest + i) % MAX_FRAMES] == page) begin
            hit = 1'b1;
         end
      end
      if (hit) begin
         hits_seen++;
      end else begin
         r.fault = 1'b1;
         faults_seen++;
         if (fault_count != TOTAL_MAX) begin
            fault_count++;
         end
         slot = (oldest + resident) % MAX_FRAMES;
         if (resident < frame_budget()) begin
            ring[slot] = page;
            resident++;
         end else begin
            // ring full or limit lowered: drop the oldest, count stays put
            r.evicted_valid = 1'b1;
            r.evicted_page  = ring[oldest];
            oldest          = (oldest + 1) % MAX_FRAMES;
            ring[slot]      = page;
            evictions_seen++;
         end
      end
      r.fault_total   = fault_count;
      r.frames_filled = FILLED_W'(resident);
      awaited_results.push_back(r);
   endfunction

   task report(string field, logic [TOTAL_W-1:0] got, logic [TOTAL_W-1:0] want);
      $display("mismatch on result %0d: %s is %0h, expected %0h",
               results_seen, field, got, want);
      mismatches++;
   endtask

   task check_result(result_type got);
      result_type want;
      results_seen++;
      if (awaited_results.size() == 0) begin
         report("item with nothing pending, fault_total", got.fault_total, '0);
         return;
      end
      want = awaited_results.pop_front();
      if (got.fault !== want.fault) begin
         report("fault", got.fault, want.fault);
      end
      if (got.evicted_valid !== want.evicted_valid) begin
         report("evicted_valid", got.evicted_valid, want.evicted_valid);
      end
      if (got.evicted_page !== want.evicted_page) begin
         report("evicted_page", got.evicted_page, want.evicted_page);
      end
      if (got.fault_total !== want.fault_total) begin
         report("fault_total", got.fault_total, want.fault_total);
      end
      if (got.frames_filled !== want.frames_filled) begin
         report("frames_filled", got.frames_filled, want.frames_filled);
      end
   endtask
endclass

module fifo_page_replacement_core_test;

   localparam int LONG_HOLD   = 60;
   localparam int TAIL_CYCLES = 8;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 100;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [PAGE_W-1:0]   req_page_number;
   logic                req_start_run;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_fault;
   logic                rsp_evicted_valid;
   logic [PAGE_W-1:0]   rsp_evicted_page;
   logic [TOTAL_W-1:0]  rsp_fault_total;
   logic [FILLED_W-1:0] rsp_frames_filled;
   logic                csr_valid;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_frames_in_use;

   page_ring_scoreboard sb = new();

   bit req_idle      = 1'b1;
   bit rsp_idle      = 1'b1;
   bit long_hold_req = 1'b0;
   int refs_sent     = 0;
   int cfg_writes    = 0;

   fifo_page_replacement_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_page_number   (req_page_number),
      .req_start_run     (req_start_run),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_fault         (rsp_fault),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total),
      .rsp_frames_filled (rsp_frames_filled),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_frames_in_use (csr_frames_in_use)
   );

   always #6 clock = ~clock;

   task automatic send_ref(page_type page, logic start);
      int gap;
      gap = req_idle ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_page_number <= page;
      req_start_run   <= start;
      do @(posedge clock); while (req_stall);
      sb.note_reference(page, start);
      refs_sent++;
   endtask

   // stop offering items and wait for every result to come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_frames(logic [CFG_W-1:0] value);
      csr_valid         <= 1'b1;
      csr_frames_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      sb.frames_cfg = value;
      cfg_writes++;
   endtask

   // mostly a working set a little larger than the frame budget, so hits,
   // fills and evictions all happen; some wide random pages and rare restarts
   task automatic run_phase(int n_items, bit mid_drain);
      page_type working_set [MAX_FRAMES + 4];
      int       set_size;
      int       i;
      int       roll;
      page_type page;
      logic     start;
      set_size = sb.frame_budget() + $urandom_range(1, 4);
      for (i = 0; i < set_size; i++) begin
         working_set[i] = page_type'($urandom);
      end
      for (i = 0; i < n_items; i++) begin
         roll  = $urandom_range(0, 99);
         start = (roll < 3);
         if (roll < 80) begin
            page = working_set[$urandom_range(0, set_size - 1)];
         end else if (roll < 84) begin
            page = roll[0] ? '1 : '0;
         end else begin
            page = page_type'($urandom);
         end
         if (roll >= 95) begin
            working_set[$urandom_range(0, set_size - 1)] = page_type'($urandom);
         end
         if (mid_drain && i == n_items / 2) begin
            drain();
         end
         send_ref(page, start);
      end
   endtask

   // result side: per item stall draw, plus a long hold-off on request
   initial begin
      int hold_left;
      result_type got;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.fault         = rsp_fault;
            got.evicted_valid = rsp_evicted_valid;
            got.evicted_page  = rsp_evicted_page;
            got.fault_total   = rsp_fault_total;
            got.frames_filled = rsp_frames_filled;
            sb.check_result(got);
            hold_left = rsp_idle ? $urandom_range(0, 13) : 0;
         end
         if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [CFG_W-1:0] cfg_plan [PHASES];
      int               k;
      int               p;
      cfg_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd8, 5'd3, 5'd12, 5'd4};
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_page_number   <= '0;
      req_start_run     <= 1'b0;
      rsp_stall         <= 1'b0;
      csr_valid         <= 1'b0;
      csr_frames_in_use <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset budget of four frames: fill, hit, evict, restart
      send_ref(16'h0000, 1'b1);
      send_ref(16'hFFFF, 1'b0);
      send_ref(16'h0000, 1'b0);
      send_ref(16'h5555, 1'b0);
      send_ref(16'hAAAA, 1'b0);
      send_ref(16'h1234, 1'b0);
      send_ref(16'h0000, 1'b0);
      send_ref(16'h1234, 1'b1);
      drain();
      // zero frames acts as one
      write_frames(5'd0);
      send_ref(16'h1234, 1'b0);
      send_ref(16'h00FF, 1'b0);
      drain();
      // limit above the ring clamps to the ring size
      write_frames(5'd31);
      for (k = 0; k <= MAX_FRAMES; k++) begin
         send_ref((k < MAX_FRAMES) ? page_type'(k * 16'h1111) : 16'h8001, k == 0);
      end
      drain();
      // limit dropped under the fill level: misses evict, count holds
      write_frames(5'd1);
      send_ref(16'h3333, 1'b0);
      send_ref(16'h7FFE, 1'b0);

      for (p = 0; p < PHASES; p++) begin
         drain();
         write_frames(cfg_plan[p]);
         req_idle = (p % 4 == 0) || (p % 4 == 2);
         rsp_idle = (p % 4 == 0) || (p % 4 == 3);
         if (p % 4 == 1) begin
            long_hold_req = 1'b1;
         end
         run_phase(PHASE_ITEMS, p % 2 == 1);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d references, %0d results: %0d faults, %0d hits, %0d evictions",
               refs_sent, sb.results_seen, sb.faults_seen, sb.hits_seen, sb.evictions_seen);
      $display("%0d restarts, frame limit written %0d times from 0 up to 31, %0d mismatches",
               sb.restarts_seen, cfg_writes, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d results outstanding", sb.pending());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
